// File: src/aes_pkg.sv
`timescale 1ns / 1ps

package aes_pkg;

  localparam int unsigned Rounds = 10;

  typedef enum logic [1:0] {
    ACT_ENCRYPT  = 2'd0,
    ACT_CFB_ENC  = 2'd1,
    ACT_CFB_DEC  = 2'd2,
    ACT_LOAD_FB  = 2'd3
  } action_t;

  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'd0,
    REG_KEY_LOW  = 1'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] data_high;
    logic [63:0] data_low;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_word_t;

  // Round unit control from the sequencer
  typedef struct packed {
    logic       load;   // start: block/key loaded, initial key addition
    logic       step;   // apply one round
    logic       last;   // final round has no column mix
    logic [7:0] rcon;   // round constant for next key
  } rnd_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  // Round constant for the key of round r (1..10)
  function automatic logic [7:0] rcon_of(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1B;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// File: src/aes_round.sv
`timescale 1ns / 1ps

// One AES round per cycle with on-the-fly key expansion
module aes_round (
  input  logic              clk,
  input  aes_pkg::rnd_ctl_t ctl,
  input  logic [127:0]      blk_in,
  input  logic [127:0]      key_in,
  output logic [127:0]      state_out
);

  logic [127:0] state_r, state_nxt;
  logic [127:0] rkey_r, rkey_nxt;
  logic [127:0] sr;
  logic [127:0] mc;
  logic [31:0]  kt;

  // next round key from current one
  always_comb begin
    kt = {aes_pkg::sbox(rkey_r[23:16]), aes_pkg::sbox(rkey_r[15:8]),
          aes_pkg::sbox(rkey_r[7:0]), aes_pkg::sbox(rkey_r[31:24])}
         ^ {ctl.rcon, 24'h0};
    rkey_nxt[127:96] = rkey_r[127:96] ^ kt;
    rkey_nxt[95:64]  = rkey_r[95:64] ^ rkey_nxt[127:96];
    rkey_nxt[63:32]  = rkey_r[63:32] ^ rkey_nxt[95:64];
    rkey_nxt[31:0]   = rkey_r[31:0] ^ rkey_nxt[63:32];
  end

  // sub bytes + shift rows; byte 4c+r at bits 127-8*(4c+r)
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127 - 8*(4*c + r) -: 8] =
          aes_pkg::sbox(state_r[127 - 8*(4*((c + r) % 4) + r) -: 8]);
      end
    end
  end

  // mix columns
  always_comb begin
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = sr[127 - 32*c -: 8];
      a1 = sr[119 - 32*c -: 8];
      a2 = sr[111 - 32*c -: 8];
      a3 = sr[103 - 32*c -: 8];
      mc[127 - 32*c -: 8] = aes_pkg::xtime(a0) ^ aes_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
      mc[119 - 32*c -: 8] = a0 ^ aes_pkg::xtime(a1) ^ aes_pkg::xtime(a2) ^ a2 ^ a3;
      mc[111 - 32*c -: 8] = a0 ^ a1 ^ aes_pkg::xtime(a2) ^ aes_pkg::xtime(a3) ^ a3;
      mc[103 - 32*c -: 8] = aes_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xtime(a3);
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (ctl.load) begin
      state_nxt = blk_in ^ key_in;
    end else if (ctl.step) begin
      state_nxt = (ctl.last ? sr : mc) ^ rkey_nxt;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
    if (ctl.load) begin
      rkey_r <= key_in;
    end else if (ctl.step) begin
      rkey_r <= rkey_nxt;
    end
  end

  assign state_out = state_r;

endmodule

// File: src/aes128_cfb_cipher.sv
`timescale 1ns / 1ps

// Channel  Ports                                   Dir  Word
// in       in_valid, in_stall(out), in_data        in   aes_pkg::in_word_t
// out      out_valid, out_stall(in), out_data      out  aes_pkg::out_word_t
// cfg      cfg_we, cfg_index, cfg_wdata            in   key halves
//
// An encrypting word runs from accept to result as one load with the
// initial key addition, then ten rounds of the shared round unit. The next word
// is taken in the cycle after the result leaves, so one word is in flight at a time.
// Load feedback gives no result.
// rst_n (sync, active low) clears key, feedback and control.
// A result held under out_stall blocks the next word.
module aes128_cfb_cipher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  aes_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output aes_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_wdata
);

  aes_pkg::state_t   state_r, state_nxt;
  logic [3:0]        rnd_r, rnd_nxt;
  logic [127:0]      key_r;
  logic [127:0]      fb_r;
  logic [127:0]      xor_r;
  logic [1:0]        act_r;
  aes_pkg::rnd_ctl_t ctl;
  logic [127:0]      enc;
  logic [127:0]      res;
  logic              acc;

  assign acc = in_valid && !in_stall;

  aes_round u_round (
    .clk       (clk),
    .ctl       (ctl),
    .blk_in    ((in_data.action == aes_pkg::ACT_ENCRYPT) ? {in_data.data_high, in_data.data_low}
                                                         : fb_r),
    .key_in    (key_r),
    .state_out (enc)
  );

  assign res = enc ^ xor_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    ctl       = '0;
    ctl.rcon  = aes_pkg::rcon_of(rnd_r);
    ctl.last  = (rnd_r == 4'(aes_pkg::Rounds));
    case (state_r)
      aes_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_data.action != aes_pkg::ACT_LOAD_FB) begin
          ctl.load  = 1'b1;
          rnd_nxt   = 4'd1;
          state_nxt = aes_pkg::ST_RUN;
        end
      end
      aes_pkg::ST_RUN: begin
        ctl.step = 1'b1;
        rnd_nxt  = rnd_r + 4'd1;
        if (ctl.last) begin
          state_nxt = aes_pkg::ST_OUT;
        end
      end
      aes_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = aes_pkg::ST_IDLE;
        end
      end
      default: state_nxt = aes_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aes_pkg::ST_IDLE;
      rnd_r   <= 4'd0;
      key_r   <= '0;
      fb_r    <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      if (cfg_we) begin
        if (cfg_index == aes_pkg::REG_KEY_HIGH) key_r[127:64] <= cfg_wdata;
        else                                    key_r[63:0]   <= cfg_wdata;
      end
      // feedback update
      if (acc) begin
        if (in_data.action == aes_pkg::ACT_LOAD_FB ||
            in_data.action == aes_pkg::ACT_CFB_DEC) begin
          fb_r <= {in_data.data_high, in_data.data_low};
        end
      end
      if (state_r == aes_pkg::ST_OUT && !out_stall && act_r == aes_pkg::ACT_CFB_ENC) begin
        fb_r <= res;
      end
    end
  end

  // word capture
  always_ff @(posedge clk) begin
    if (acc) begin
      act_r <= in_data.action;
      xor_r <= (in_data.action == aes_pkg::ACT_ENCRYPT) ? 128'h0
                                                        : {in_data.data_high, in_data.data_low};
    end
  end

  assign out_data.result_high = res[127:64];
  assign out_data.result_low  = res[63:0];

endmodule

// File: tb/aes128_cfb_cipher_check.sv
`timescale 1ns / 1ps

module aes128_cfb_cipher_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  aes_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  aes_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_wdata,
  output int                 errors,
  output int                 pending
);

  localparam logic [7:0] SUB_BOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  logic [63:0] key_hi, key_lo;
  logic [127:0] chain_block;
  aes_pkg::out_word_t expected_words[$];

  function automatic logic [7:0] dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  // AES-128 forward cipher, byte 0 in the top bits
  function automatic logic [127:0] aes_encrypt(input logic [127:0] blk_in,
                                               input logic [127:0] key);
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0] s [16];
    logic [7:0] m [16];
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] rc;
    for (int i = 0; i < 4; i++) w[i] = key[127 - 32*i -: 32];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {SUB_BOX[t[31:24]], SUB_BOX[t[23:16]], SUB_BOX[t[15:8]], SUB_BOX[t[7:0]]};
        t[31:24] ^= rc;
        rc = dbl(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int i = 0; i < 16; i++) s[i] = blk_in[127 - 8*i -: 8] ^ w[i/4][31 - 8*(i%4) -: 8];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      // sub bytes and shift rows
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) m[4*c + r] = SUB_BOX[s[4*((c + r) % 4) + r]];
      for (int c = 0; c < 4; c++) begin
        a0 = m[4*c]; a1 = m[4*c+1]; a2 = m[4*c+2]; a3 = m[4*c+3];
        if (rnd != 10) begin
          s[4*c]   = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
          s[4*c+1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
          s[4*c+2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
          s[4*c+3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
        end else begin
          s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
        end
        for (int r = 0; r < 4; r++) s[4*c+r] ^= w[4*rnd + c][31 - 8*r -: 8];
      end
    end
    for (int i = 0; i < 16; i++) blk_in[127 - 8*i -: 8] = s[i];
    return blk_in;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  assign pending = expected_words.size();

  always @(posedge clk) begin
    logic [127:0] din, enc;
    aes_pkg::out_word_t exp_w;
    if (!rst_n) begin
      key_hi <= '0;
      key_lo <= '0;
      chain_block = '0;
      expected_words.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == aes_pkg::REG_KEY_HIGH) key_hi <= cfg_wdata;
        else key_lo <= cfg_wdata;
      end
      // compare a delivered word
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected result word");
        end else begin
          exp_w = expected_words.pop_front();
          if (out_data.result_high !== exp_w.result_high)
            report_mismatch($sformatf("result_high %h exp %h",
                                      out_data.result_high, exp_w.result_high));
          if (out_data.result_low !== exp_w.result_low)
            report_mismatch($sformatf("result_low %h exp %h",
                                      out_data.result_low, exp_w.result_low));
        end
      end
      // predict from an accepted word
      if (in_valid && !in_stall) begin
        din = {in_data.data_high, in_data.data_low};
        case (aes_pkg::action_t'(in_data.action))
          aes_pkg::ACT_LOAD_FB: chain_block = din;
          aes_pkg::ACT_ENCRYPT: begin
            enc = aes_encrypt(din, {key_hi, key_lo});
            expected_words.push_back(enc);
          end
          default: begin
            enc = din ^ aes_encrypt(chain_block, {key_hi, key_lo});
            expected_words.push_back(enc);
            chain_block = (in_data.action == aes_pkg::ACT_CFB_ENC) ? enc : din;
          end
        endcase
      end
    end
  end
endmodule

// File: tb/aes128_cfb_cipher_test.sv
`timescale 1ns / 1ps

module aes128_cfb_cipher_test;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  aes_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  aes_pkg::out_word_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [63:0] cfg_wdata = '0;
  int errors, pending;
  int cycles = 0;
  int send_idle = 0, recv_idle = 0;

  always #5 clk = ~clk;

  aes128_cfb_cipher dut (.*);
  aes128_cfb_cipher_check checker_i (.*);

  // receiver stall and cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_stall <= ($urandom_range(99) < recv_idle);
    if (cycles > 400000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // valid stays up after an accept until the next word or an idle cycle replaces it
  task automatic send_word(input aes_pkg::action_t act, input logic [63:0] hi,
                           input logic [63:0] lo);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{action: act, data_high: hi, data_low: lo};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid and wait for the block to drain
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
    drain();
    repeat (16) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= aes_pkg::REG_KEY_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= aes_pkg::REG_KEY_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_words(input int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(9);
      // mostly chained CFB traffic, some reloads and plain blocks
      if (pick < 1) send_word(aes_pkg::ACT_LOAD_FB, rnd64(), rnd64());
      else if (pick < 3) send_word(aes_pkg::ACT_ENCRYPT, rnd64(), rnd64());
      else if (pick < 6) send_word(aes_pkg::ACT_CFB_ENC, rnd64(), rnd64());
      else send_word(aes_pkg::ACT_CFB_DEC, rnd64(), rnd64());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: zero key, extremes, every action
    send_word(aes_pkg::ACT_ENCRYPT, '0, '0);
    send_word(aes_pkg::ACT_CFB_ENC, '0, '0);
    send_word(aes_pkg::ACT_CFB_DEC, '1, '1);
    write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_word(aes_pkg::ACT_ENCRYPT, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
    send_word(aes_pkg::ACT_LOAD_FB, 64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_word(aes_pkg::ACT_CFB_ENC, 64'h6bc1bee22e409f96, 64'he93d7e117393172a);
    send_word(aes_pkg::ACT_CFB_ENC, 64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51);
    send_word(aes_pkg::ACT_LOAD_FB, 64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_word(aes_pkg::ACT_CFB_DEC, 64'h3b3fd92eb72dad20, 64'h333449f8e83cfb4a);
    send_word(aes_pkg::ACT_CFB_DEC, '0, '1);
    send_word(aes_pkg::ACT_LOAD_FB, '1, '1);
    send_word(aes_pkg::ACT_CFB_ENC, '1, '0);
    write_key('1, '1);
    send_word(aes_pkg::ACT_ENCRYPT, '1, '1);
    send_word(aes_pkg::ACT_CFB_DEC, 64'h8000000000000000, 64'h1);
    // random phases with key changes between them
    send_idle = 21; recv_idle = 70;
    write_key(rnd64(), rnd64());
    random_words(230);
    send_idle = 70; recv_idle = 21;
    write_key(rnd64(), '0);
    random_words(230);
    send_idle = 0; recv_idle = 0;
    write_key(rnd64(), rnd64());
    random_words(240);
    drain();
    repeat (30) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
